### hw/rtl/rmsa_pkg.sv
// ----------------------------------------------------------------------------
// rmsa_pkg
// shared types and constants of the running mean / deviation accumulator
// ----------------------------------------------------------------------------
package rmsa_pkg;

    // fixed field widths
    localparam int SUM_W     = 40;
    localparam int SQ_W      = 64;
    localparam int WIDE_W    = 128;
    localparam int MAG_W     = 40;
    localparam int MPL_W     = 40;
    localparam int ROOT_BITS = 23;
    localparam int STEP_W    = 8;
    localparam int BIT_W     = 5;

    // command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;

    // decoded item kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_REPORT = 2'd3;

    // multiplier target select
    localparam logic [1:0] MSEL_NSQ  = 2'd0;
    localparam logic [1:0] MSEL_MAG2 = 2'd1;
    localparam logic [1:0] MSEL_DEN  = 2'd2;

    // divider operand select
    localparam logic DSEL_MEAN = 1'b0;
    localparam logic DSEL_VAR  = 1'b1;

    typedef struct packed {
        logic             accept;
        logic             add_write;
        logic             latch;
        logic             mul_start;
        logic             mul_step;
        logic [1:0]       mul_sel;
        logic             div_start;
        logic             div_step;
        logic             div_sel;
        logic             root_start;
        logic             root_step;
        logic [BIT_W-1:0] root_bit;
        logic             out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       out_full;
    } t_dp_status;

endpackage

### hw/rtl/rmsa_ctrl.sv
// ----------------------------------------------------------------------------
// rmsa_ctrl
// sequencer for add, clear and the multi-step report computation
// ----------------------------------------------------------------------------
module rmsa_ctrl #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  rmsa_pkg::t_dp_status  i_status,
    output rmsa_pkg::t_ctrl_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ADD_WR = 4'd1;
    localparam logic [3:0] S_LOAD   = 4'd2;
    localparam logic [3:0] S_MUL_A  = 4'd3;
    localparam logic [3:0] S_MUL_B  = 4'd4;
    localparam logic [3:0] S_MUL_D  = 4'd5;
    localparam logic [3:0] S_DIV_M  = 4'd6;
    localparam logic [3:0] S_DIV_V  = 4'd7;
    localparam logic [3:0] S_SQRT   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    localparam logic [rmsa_pkg::STEP_W-1:0] STEPS_CNT  = rmsa_pkg::STEP_W'(COUNT_BITS);
    localparam logic [rmsa_pkg::STEP_W-1:0] STEPS_MAG  = rmsa_pkg::STEP_W'(rmsa_pkg::MAG_W);
    localparam logic [rmsa_pkg::STEP_W-1:0] STEPS_WIDE = rmsa_pkg::STEP_W'(rmsa_pkg::WIDE_W);
    localparam logic [rmsa_pkg::STEP_W-1:0] STEPS_ROOT =
        rmsa_pkg::STEP_W'(rmsa_pkg::ROOT_BITS);

    logic [3:0]                  r_state, n_state;
    logic [rmsa_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic                        r_first, n_first;
    logic                        in_phase;
    logic [rmsa_pkg::STEP_W-1:0] ph_steps;
    logic [3:0]                  ph_next;

    always_comb begin
        o_cmd    = '0;
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_first  = r_first;
        in_phase = 1'b0;
        ph_steps = STEPS_CNT;
        ph_next  = S_IDLE;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    case (i_status.kind)
                        rmsa_pkg::KIND_ADD:    n_state = S_ADD_WR;
                        rmsa_pkg::KIND_REPORT: n_state = S_LOAD;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_WR: begin
                o_cmd.add_write = 1'b1;
                n_state         = S_IDLE;
            end
            S_LOAD: begin
                o_cmd.latch = 1'b1;
                n_state     = S_MUL_A;
                n_first     = 1'b1;
            end
            S_MUL_A, S_MUL_B, S_MUL_D: begin
                in_phase        = 1'b1;
                o_cmd.mul_start = r_first;
                o_cmd.mul_step  = !r_first;
                if (r_state == S_MUL_A) begin
                    o_cmd.mul_sel = rmsa_pkg::MSEL_NSQ;
                    ph_next       = S_MUL_B;
                end else if (r_state == S_MUL_B) begin
                    o_cmd.mul_sel = rmsa_pkg::MSEL_MAG2;
                    ph_steps      = STEPS_MAG;
                    ph_next       = S_MUL_D;
                end else begin
                    o_cmd.mul_sel = rmsa_pkg::MSEL_DEN;
                    ph_next       = S_DIV_M;
                end
            end
            S_DIV_M: begin
                in_phase        = 1'b1;
                o_cmd.div_start = r_first;
                o_cmd.div_step  = !r_first;
                o_cmd.div_sel   = rmsa_pkg::DSEL_MEAN;
                ph_steps        = STEPS_MAG;
                ph_next         = S_DIV_V;
            end
            S_DIV_V: begin
                in_phase        = 1'b1;
                o_cmd.div_start = r_first;
                o_cmd.div_step  = !r_first;
                o_cmd.div_sel   = rmsa_pkg::DSEL_VAR;
                ph_steps        = STEPS_WIDE;
                ph_next         = S_SQRT;
            end
            S_SQRT: begin
                in_phase         = 1'b1;
                o_cmd.root_start = r_first;
                o_cmd.root_step  = !r_first;
                o_cmd.root_bit   = r_cnt[rmsa_pkg::BIT_W-1:0];
                ph_steps         = STEPS_ROOT;
                ph_next          = S_DONE;
            end
            S_DONE: begin
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (in_phase) begin
            if (r_first) begin
                n_cnt   = ph_steps - 1'b1;
                n_first = 1'b0;
            end else if (r_cnt == '0) begin
                n_state = ph_next;
                n_first = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_first <= n_first;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_add_then_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_status.kind == rmsa_pkg::KIND_ADD) |=> r_state == S_ADD_WR)
        else $error("add transfer did not reach write state");

    a_write_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_WR) |=> r_state == S_IDLE)
        else $error("write state did not return to idle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.out_load && i_status.out_full))
        else $error("result loaded over a pending result");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.mul_step, o_cmd.div_step, o_cmd.root_step, o_cmd.add_write}))
        else $error("more than one unit stepping");

endmodule

### hw/rtl/rmsa_dp.sv
// ----------------------------------------------------------------------------
// rmsa_dp
// accumulator memories, counts, shift-add multiplier, divider and root unit
// ----------------------------------------------------------------------------
module rmsa_dp #(
    parameter int SLOTS      = 16,
    parameter int CHANNELS   = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rmsa_pkg::t_ctrl_cmd        i_cmd,
    output rmsa_pkg::t_dp_status       o_status,
    input  logic [1:0]                 i_command,
    input  logic [3:0]                 i_slot,
    input  logic [2:0]                 i_channel,
    input  logic signed [23:0]         i_sample,
    input  logic                       i_end_of_event,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic signed [39:0]         o_total,
    output logic signed [23:0]         o_mean_value,
    output logic signed [23:0]         o_std_dev,
    output logic [15:0]                o_event_count,
    output logic                       o_count_saturated
);

    localparam int DEPTH  = SLOTS * CHANNELS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SAW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int D_W    = 2 * COUNT_BITS;
    localparam int PROD_W = 2 * rmsa_pkg::MAG_W;
    localparam int R2_W   = 2 * rmsa_pkg::ROOT_BITS;
    localparam int WW     = rmsa_pkg::WIDE_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [rmsa_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(rmsa_pkg::SUM_W-1){1'b1}}};
    localparam logic [rmsa_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(rmsa_pkg::SUM_W-1){1'b0}}};
    localparam logic [rmsa_pkg::MAG_W-1:0] Q24_MAX = rmsa_pkg::MAG_W'(24'h7FFFFF);
    localparam logic [rmsa_pkg::MAG_W-1:0] Q24_NEG = rmsa_pkg::MAG_W'(25'h0800000);

    // accumulator memories
    logic [rmsa_pkg::SUM_W-1:0] mem_sum [DEPTH];
    logic [rmsa_pkg::SQ_W-1:0]  mem_sq  [DEPTH];
    logic [DEPTH-1:0]           r_vld;
    logic [COUNT_BITS-1:0]      r_cnt   [SLOTS];
    logic [SLOTS-1:0]           r_satf;

    // decode
    logic       slot_ok, ch_ok;
    logic [1:0] kind;
    logic [15:0] row_base, addr_full;
    logic [AW-1:0] in_addr;
    logic [7:0]  slot_ext;
    logic [SAW-1:0] slot_idx;

    always_comb begin
        slot_ok   = 9'(i_slot) < 9'(SLOTS);
        ch_ok     = 7'(i_channel) < 7'(CHANNELS);
        row_base  = 16'(i_slot) * 16'(CHANNELS);
        addr_full = row_base + 16'(i_channel);
        in_addr   = addr_full[AW-1:0];
        slot_ext  = 8'(i_slot);
        slot_idx  = slot_ext[SAW-1:0];
        kind      = rmsa_pkg::KIND_NONE;
        if (slot_ok) begin
            case (i_command)
                rmsa_pkg::CMD_CLEAR:  kind = rmsa_pkg::KIND_CLEAR;
                rmsa_pkg::CMD_ADD:    kind = ch_ok ? rmsa_pkg::KIND_ADD : rmsa_pkg::KIND_NONE;
                rmsa_pkg::CMD_REPORT: kind = ch_ok ? rmsa_pkg::KIND_REPORT
                                                   : rmsa_pkg::KIND_NONE;
                default:              kind = rmsa_pkg::KIND_NONE;
            endcase
        end
    end

    logic r_out_valid;
    assign o_status.kind     = kind;
    assign o_status.out_full = r_out_valid && i_out_stall;

    // captured item and read data
    logic [AW-1:0]              r_addr;
    logic [SAW-1:0]             r_sidx;
    logic signed [23:0]         r_sample;
    logic                       r_eoe;
    logic [46:0]                r_v2;
    logic [rmsa_pkg::SUM_W-1:0] r_rd_sum;
    logic [rmsa_pkg::SQ_W-1:0]  r_rd_sq;
    logic                       r_rd_vld;
    logic [COUNT_BITS-1:0]      r_n;
    logic                       r_sat;
    logic signed [47:0]         v2_full;

    assign v2_full = i_sample * i_sample;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_sum <= mem_sum[in_addr];
            r_rd_sq  <= mem_sq[in_addr];
            r_rd_vld <= r_vld[in_addr];
            r_addr   <= in_addr;
            r_sidx   <= slot_idx;
            r_sample <= i_sample;
            r_eoe    <= i_end_of_event;
            r_v2     <= v2_full[46:0];
            r_n      <= r_cnt[slot_idx];
            r_sat    <= r_satf[slot_idx];
        end
    end

    // add read-modify-write
    logic [rmsa_pkg::SUM_W-1:0] cur_sum, n_sum_wr;
    logic [rmsa_pkg::SQ_W-1:0]  cur_sq, n_sq_wr;
    logic [40:0]                s41;
    logic [64:0]                sq65;

    always_comb begin
        cur_sum = r_rd_vld ? r_rd_sum : '0;
        cur_sq  = r_rd_vld ? r_rd_sq  : '0;
        s41     = {cur_sum[39], cur_sum} + {{17{r_sample[23]}}, r_sample};
        if (s41[40] != s41[39]) begin
            n_sum_wr = s41[40] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum_wr = s41[39:0];
        end
        sq65    = {1'b0, cur_sq} + 65'(r_v2);
        n_sq_wr = sq65[64] ? '1 : sq65[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_write) begin
            mem_sum[r_addr] <= n_sum_wr;
            mem_sq[r_addr]  <= n_sq_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_satf <= '0;
            for (int s = 0; s < SLOTS; s++) begin
                r_cnt[s] <= '0;
            end
        end else begin
            if (i_cmd.add_write) begin
                r_vld[r_addr] <= 1'b1;
                if (r_eoe) begin
                    if (r_cnt[r_sidx] == CNT_MAX) begin
                        r_satf[r_sidx] <= 1'b1;
                    end else begin
                        r_cnt[r_sidx] <= r_cnt[r_sidx] + 1'b1;
                    end
                end
            end
            if (i_cmd.accept && kind == rmsa_pkg::KIND_CLEAR) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    r_vld[AW'(row_base + 16'(c))] <= 1'b0;
                end
                r_cnt[slot_idx]  <= '0;
                r_satf[slot_idx] <= 1'b0;
            end
        end
    end

    // report operands
    logic [rmsa_pkg::SUM_W-1:0] r_sum;
    logic [rmsa_pkg::SQ_W-1:0]  r_sq;
    logic [rmsa_pkg::MAG_W-1:0] r_mag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_sum <= cur_sum;
            r_sq  <= cur_sq;
            r_mag <= cur_sum[39] ? (~cur_sum + 1'b1) : cur_sum;
        end
    end

    // shift-add multiplier
    logic [WW-1:0]             r_mcand;
    logic [rmsa_pkg::MPL_W-1:0] r_mplier;
    logic [WW-1:0]             r_a;
    logic [PROD_W-1:0]         r_b;
    logic [D_W-1:0]            r_d;
    logic [COUNT_BITS-1:0]     n_dec;

    assign n_dec = r_n - COUNT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            case (i_cmd.mul_sel)
                rmsa_pkg::MSEL_NSQ: begin
                    r_mcand  <= WW'(r_sq);
                    r_mplier <= rmsa_pkg::MPL_W'(r_n);
                    r_a      <= '0;
                end
                rmsa_pkg::MSEL_MAG2: begin
                    r_mcand  <= WW'(r_mag);
                    r_mplier <= r_mag;
                    r_b      <= '0;
                end
                default: begin
                    r_mcand  <= WW'(r_n);
                    r_mplier <= rmsa_pkg::MPL_W'(n_dec);
                    r_d      <= '0;
                end
            endcase
        end else if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                case (i_cmd.mul_sel)
                    rmsa_pkg::MSEL_NSQ:  r_a <= r_a + r_mcand;
                    rmsa_pkg::MSEL_MAG2: r_b <= r_b + r_mcand[PROD_W-1:0];
                    default:             r_d <= r_d + r_mcand[D_W-1:0];
                endcase
            end
            r_mcand  <= {r_mcand[WW-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[rmsa_pkg::MPL_W-1:1]};
        end
    end

    // restoring divider, one quotient bit per step
    logic [WW-1:0]              r_dn;
    logic [D_W-1:0]             r_dr, r_dd;
    logic [rmsa_pkg::MAG_W-1:0] r_mean_q;
    logic                       r_neg;
    logic [D_W:0]               trial, diff;
    logic                       ge;

    always_comb begin
        trial = {r_dr, r_dn[WW-1]};
        ge    = trial >= {1'b0, r_dd};
        diff  = trial - {1'b0, r_dd};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dr <= '0;
            if (i_cmd.div_sel == rmsa_pkg::DSEL_MEAN) begin
                r_dn <= {r_mag, {(WW - rmsa_pkg::MAG_W){1'b0}}};
                r_dd <= D_W'(r_n);
            end else begin
                r_mean_q <= r_dn[rmsa_pkg::MAG_W-1:0];
                r_neg    <= WW'(r_b) > r_a;
                r_dn     <= (WW'(r_b) > r_a) ? '0 : (r_a - WW'(r_b));
                r_dd     <= r_d;
            end
        end else if (i_cmd.div_step) begin
            r_dr <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
            r_dn <= {r_dn[WW-2:0], ge};
        end
    end

    // bitwise integer root of the quotient, all ones when the quotient is too wide
    logic [rmsa_pkg::ROOT_BITS-1:0] r_root;
    logic [R2_W-1:0]                r_r2;
    logic [R2_W:0]                  t2;
    logic                           root_ok;

    always_comb begin
        t2 = (R2_W+1)'(r_r2)
           + ((R2_W+1)'(r_root) << ({1'b0, i_cmd.root_bit} + 6'd1))
           + ((R2_W+1)'(1) << {i_cmd.root_bit, 1'b0});
        root_ok = (r_dn[WW-1:R2_W] != '0) || (t2 <= (R2_W+1)'(r_dn[R2_W-1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_start) begin
            r_root <= '0;
            r_r2   <= '0;
        end else if (i_cmd.root_step && root_ok) begin
            r_root <= r_root | (rmsa_pkg::ROOT_BITS'(1) << i_cmd.root_bit);
            r_r2   <= t2[R2_W-1:0];
        end
    end

    // result formatting
    logic [23:0] mean24, dev24;
    logic [rmsa_pkg::MAG_W-1:0] neg_q;
    logic [23:0] n_ext;

    always_comb begin
        neg_q = ~r_mean_q + 1'b1;
        n_ext = 24'(r_n);
        if (r_n == '0) begin
            mean24 = '0;
        end else if (r_sum[39]) begin
            mean24 = (r_mean_q > Q24_NEG) ? 24'h800000 : neg_q[23:0];
        end else begin
            mean24 = (r_mean_q > Q24_MAX) ? 24'h7FFFFF : r_mean_q[23:0];
        end
        if (r_n == '0) begin
            dev24 = '0;
        end else if (r_n == COUNT_BITS'(1)) begin
            dev24 = mean24;
        end else if (r_neg) begin
            dev24 = '0;
        end else begin
            dev24 = {1'b0, r_root};
        end
    end

    logic [39:0] r_o_total;
    logic [23:0] r_o_mean, r_o_dev;
    logic [15:0] r_o_cnt;
    logic        r_o_sat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_total <= r_sum;
            r_o_mean  <= mean24;
            r_o_dev   <= dev24;
            r_o_cnt   <= n_ext[15:0];
            r_o_sat   <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_total           = r_o_total;
    assign o_mean_value      = r_o_mean;
    assign o_std_dev         = r_o_dev;
    assign o_event_count     = r_o_cnt;
    assign o_count_saturated = r_o_sat;

endmodule

### hw/rtl/running_mean_stddev_accumulator_core.sv
// ----------------------------------------------------------------------------
// running_mean_stddev_accumulator_core
// per-slot, per-channel running sums with mean and sample deviation report
// ----------------------------------------------------------------------------
// one item is handled at a time. an add transfer reads the memories when it is
// accepted and then writes back; a clear is done when it is accepted, and items
// that address no valid slot or channel are dropped. before its result transfer
// is offered, a report runs a shift-add multiplier three times (n*sumsq, sum^2
// and n*(n-1)), a one-bit-per-cycle divider twice (40 steps for the mean, 128
// for the variance quotient) and a 23-step bitwise root. the result sits in an
// output register, so the next item can be accepted while it waits; a second
// report stalls only at its last step if the first result is still not taken.
// the accumulator memories need no clearing pass: each entry has a valid bit
// that reset and the clear command drop, and an invalid entry reads as zero.
module running_mean_stddev_accumulator_core #(
    parameter int SLOTS      = 16,
    parameter int CHANNELS   = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [3:0]         i_slot,
    input  logic [2:0]         i_channel,
    input  logic signed [23:0] i_sample,
    input  logic               i_end_of_event,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [39:0] o_total,
    output logic signed [23:0] o_mean_value,
    output logic signed [23:0] o_std_dev,
    output logic [15:0]        o_event_count,
    output logic               o_count_saturated
);

    // command and status between sequencer and datapath
    rmsa_pkg::t_ctrl_cmd  cmd;
    rmsa_pkg::t_dp_status status;

    rmsa_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // memories, counters and the arithmetic units
    rmsa_dp #(
        .SLOTS      (SLOTS),
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_command         (i_command),
        .i_slot            (i_slot),
        .i_channel         (i_channel),
        .i_sample          (i_sample),
        .i_end_of_event    (i_end_of_event),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_total           (o_total),
        .o_mean_value      (o_mean_value),
        .o_std_dev         (o_std_dev),
        .o_event_count     (o_event_count),
        .o_count_saturated (o_count_saturated)
    );

endmodule
